// File: rtl/spa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_pkg
// Shared widths, request and register codes, reset values and transaction
// payload types of the slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

  localparam int SLOTS_DEFAULT = 64;

  localparam int REQ_W     = 3;
  localparam int IDX_W     = 6;
  localparam int VAL_W     = 64;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 64;

  localparam logic [REQ_W-1:0] REQ_ALLOC = 3'd0;
  localparam logic [REQ_W-1:0] REQ_FREE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SWEEP = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd3;
  localparam logic [REQ_W-1:0] REQ_INIT  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT   = 2'd2;

  localparam logic [CNT_W-1:0] SLOT_LIMIT_DEFAULT   = 7'd0;
  localparam logic             SWEEP_ENABLE_DEFAULT = 1'b1;
  localparam logic [VAL_W-1:0] IDLE_LIMIT_DEFAULT   = 64'd5000000000;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [IDX_W-1:0] slot_index;
    logic [VAL_W-1:0] final_value;
    logic [VAL_W-1:0] now_time;
    logic [CNT_W-1:0] prefill_count;
  } spa_req_t;

  typedef struct packed {
    logic             ok;
    logic [IDX_W-1:0] granted_slot;
    logic             reused;
    logic [CNT_W-1:0] swept_count;
    logic [CNT_W-1:0] live_count;
    logic [CNT_W-1:0] grown_count;
    logic [VAL_W-1:0] grant_total;
    logic [VAL_W-1:0] reuse_total;
    logic [VAL_W-1:0] fresh_total;
    logic [VAL_W-1:0] release_total;
  } spa_res_t;

endpackage

// File: rtl/spa_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spa_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface spa_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/slot_pool_allocator_with_aging.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_allocator_with_aging
// Pool of reusable slots with allocate, free, idle sweep, statistics clear
// and prefill init; every request returns one result with the counters.
// ----------------------------------------------------------------------------
// One request is in work at a time; a new request transaction is taken while
// the previous result still waits on the output register. A request is taken
// in S_IDLE, runs in S_EXEC and loads its result in S_DONE; allocate scans the
// valid/busy bits one slot per cycle over the grown slots, then grows one if
// the limit allows; sweep visits each grown slot in S_SWEEP_RD on the
// birth-time memory read port and in S_SWEEP_CK on the shared 64-bit age
// subtract and compare; init writes min(prefill_count, limit) birth stamps,
// one per cycle. Free, clear and unknown requests go straight to S_DONE.
module slot_pool_allocator_with_aging #(
  parameter int SLOTS = spa_pkg::SLOTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  spa_stream_if.sink                    in_ch,
  spa_stream_if.source                  out_ch,
  input  logic                          cfg_we,
  input  logic [spa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spa_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import spa_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = CW + CNT_W;
  localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ALLOC_SCAN,
    S_SWEEP_RD,
    S_SWEEP_CK,
    S_INIT_WR,
    S_DONE
  } state_t;

  state_t           state_r;
  logic [CNT_W-1:0] slot_limit_r;
  logic             sweep_en_r;
  logic [VAL_W-1:0] idle_limit_r;

  logic [SLOTS-1:0] valid_r;
  logic [SLOTS-1:0] busy_r;
  logic [CW-1:0]    grown_r;
  logic [CW-1:0]    live_r;
  logic [CW-1:0]    scan_r;
  logic [CW-1:0]    swept_r;
  logic [VAL_W-1:0] grants_r;
  logic [VAL_W-1:0] reuses_r;
  logic [VAL_W-1:0] freshes_r;
  logic [VAL_W-1:0] releases_r;

  spa_req_t         item_r;
  logic             ok_r;
  logic [IW-1:0]    gslot_r;
  logic             reused_r;
  spa_res_t         out_r;
  logic             out_valid_r;

  logic [VAL_W-1:0] birth_mem [SLOTS];
  logic [VAL_W-1:0] final_mem [SLOTS];
  logic [VAL_W-1:0] birth_rd_r;

  logic [CW-1:0]    limit;
  logic [CW-1:0]    init_n;
  logic [SLOTS-1:0] init_mask;
  logic [IW-1:0]    scan_idx;
  logic [IW-1:0]    grown_idx;
  logic [IW-1:0]    free_idx;
  logic             scan_in;
  logic             scan_hit;
  logic             scan_last;
  logic             can_grow;
  logic             free_ok;
  logic [VAL_W-1:0] age;
  logic             sweep_hit;
  logic             birth_we;
  logic [IW-1:0]    birth_addr;
  logic             final_we;
  logic [IW-1:0]    final_addr;
  logic [VAL_W-1:0] final_wdata;
  logic [EW-1:0]    gslot_e;
  logic [EW-1:0]    swept_e;
  logic [EW-1:0]    live_e;
  logic [EW-1:0]    grown_e;
  spa_res_t         res;

  always_comb begin
    if (slot_limit_r == '0 || EW'(slot_limit_r) > EW'(SLOTS)) begin
      limit = SLOTS_C;
    end else begin
      limit = CW'(slot_limit_r);
    end
    if (EW'(item_r.prefill_count) < EW'(limit)) begin
      init_n = CW'(item_r.prefill_count);
    end else begin
      init_n = limit;
    end
    for (int i = 0; i < SLOTS; i++) begin
      init_mask[i] = (i < int'(init_n));
    end
  end

  assign scan_idx  = scan_r[IW-1:0];
  assign grown_idx = grown_r[IW-1:0];
  assign free_idx  = IW'(item_r.slot_index);
  assign scan_in   = scan_r < grown_r;
  assign scan_hit  = scan_in && valid_r[scan_idx] && !busy_r[scan_idx];
  assign scan_last = (scan_r + CW'(1)) >= grown_r;
  assign can_grow  = grown_r < limit;
  assign free_ok   = (EW'(item_r.slot_index) < EW'(grown_r)) && busy_r[free_idx];
  assign age       = item_r.now_time - birth_rd_r;
  assign sweep_hit = valid_r[scan_idx] && !busy_r[scan_idx] && (age > idle_limit_r);

  always_comb begin
    birth_we    = 1'b0;
    birth_addr  = grown_idx;
    final_we    = 1'b0;
    final_addr  = grown_idx;
    final_wdata = '0;
    case (state_r)
      S_EXEC: begin
        if (item_r.req_type == REQ_FREE && free_ok) begin
          final_we    = 1'b1;
          final_addr  = free_idx;
          final_wdata = item_r.final_value;
        end
      end
      S_ALLOC_SCAN: begin
        if (!scan_in && can_grow) begin
          birth_we = 1'b1;
          final_we = 1'b1;
        end
      end
      S_INIT_WR: begin
        birth_we   = 1'b1;
        birth_addr = scan_idx;
        final_we   = 1'b1;
        final_addr = scan_idx;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (birth_we) begin
      birth_mem[birth_addr] <= item_r.now_time;
    end
    birth_rd_r <= birth_mem[scan_idx];
  end

  always_ff @(posedge clk) begin
    if (final_we) begin
      final_mem[final_addr] <= final_wdata;
    end
  end

  always_comb begin
    gslot_e = EW'(gslot_r);
    swept_e = EW'(swept_r);
    live_e  = EW'(live_r);
    grown_e = EW'(grown_r);
    res.ok            = ok_r;
    res.granted_slot  = gslot_e[IDX_W-1:0];
    res.reused        = reused_r;
    res.swept_count   = swept_e[CNT_W-1:0];
    res.live_count    = live_e[CNT_W-1:0];
    res.grown_count   = grown_e[CNT_W-1:0];
    res.grant_total   = grants_r;
    res.reuse_total   = reuses_r;
    res.fresh_total   = freshes_r;
    res.release_total = releases_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_limit_r <= SLOT_LIMIT_DEFAULT;
      sweep_en_r   <= SWEEP_ENABLE_DEFAULT;
      idle_limit_r <= IDLE_LIMIT_DEFAULT;
      valid_r      <= '0;
      busy_r       <= '0;
      grown_r      <= '0;
      live_r       <= '0;
      grants_r     <= '0;
      reuses_r     <= '0;
      freshes_r    <= '0;
      releases_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOT_LIMIT:   slot_limit_r <= cfg_wdata[CNT_W-1:0];
          CFG_SWEEP_ENABLE: sweep_en_r   <= cfg_wdata[0];
          CFG_IDLE_LIMIT:   idle_limit_r <= cfg_wdata;
          default: begin
          end
        endcase
      end

      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            item_r   <= in_ch.data;
            ok_r     <= 1'b0;
            gslot_r  <= '0;
            reused_r <= 1'b0;
            swept_r  <= '0;
            state_r  <= S_EXEC;
          end
        end
        S_EXEC: begin
          scan_r <= '0;
          case (item_r.req_type)
            REQ_ALLOC: begin
              state_r <= S_ALLOC_SCAN;
            end
            REQ_FREE: begin
              if (free_ok) begin
                busy_r[free_idx] <= 1'b0;
                if (live_r != '0) begin
                  live_r <= live_r - CW'(1);
                end
                releases_r <= releases_r + VAL_W'(1);
                ok_r       <= 1'b1;
              end
              state_r <= S_DONE;
            end
            REQ_SWEEP: begin
              state_r <= (sweep_en_r && grown_r != '0) ? S_SWEEP_RD : S_DONE;
            end
            REQ_CLEAR: begin
              grants_r   <= '0;
              reuses_r   <= '0;
              freshes_r  <= '0;
              releases_r <= '0;
              ok_r       <= 1'b1;
              state_r    <= S_DONE;
            end
            REQ_INIT: begin
              if (item_r.prefill_count != '0) begin
                valid_r    <= init_mask;
                busy_r     <= '0;
                grown_r    <= init_n;
                live_r     <= '0;
                grants_r   <= '0;
                reuses_r   <= '0;
                freshes_r  <= '0;
                releases_r <= '0;
                ok_r       <= 1'b1;
                state_r    <= S_INIT_WR;
              end else begin
                state_r <= S_DONE;
              end
            end
            default: begin
              state_r <= S_DONE;
            end
          endcase
        end
        S_ALLOC_SCAN: begin
          if (scan_in) begin
            if (scan_hit) begin
              busy_r[scan_idx] <= 1'b1;
              gslot_r          <= scan_idx;
              reused_r         <= 1'b1;
              ok_r             <= 1'b1;
              live_r           <= live_r + CW'(1);
              grants_r         <= grants_r + VAL_W'(1);
              reuses_r         <= reuses_r + VAL_W'(1);
              state_r          <= S_DONE;
            end else begin
              scan_r <= scan_r + CW'(1);
            end
          end else begin
            if (can_grow) begin
              valid_r[grown_idx] <= 1'b1;
              busy_r[grown_idx]  <= 1'b1;
              grown_r            <= grown_r + CW'(1);
              gslot_r            <= grown_idx;
              ok_r               <= 1'b1;
              live_r             <= live_r + CW'(1);
              grants_r           <= grants_r + VAL_W'(1);
              freshes_r          <= freshes_r + VAL_W'(1);
            end
            state_r <= S_DONE;
          end
        end
        S_SWEEP_RD: begin
          state_r <= S_SWEEP_CK;
        end
        S_SWEEP_CK: begin
          if (sweep_hit) begin
            valid_r[scan_idx] <= 1'b0;
            swept_r           <= swept_r + CW'(1);
            ok_r              <= 1'b1;
          end
          if (scan_last) begin
            state_r <= S_DONE;
          end else begin
            scan_r  <= scan_r + CW'(1);
            state_r <= S_SWEEP_RD;
          end
        end
        S_INIT_WR: begin
          if (scan_last) begin
            state_r <= S_DONE;
          end else begin
            scan_r <= scan_r + CW'(1);
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_r       <= res;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_live_matches_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(busy_r) == int'(live_r))
    else $error("live count differs from busy slots");

  a_busy_is_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r & ~valid_r) == '0)
    else $error("busy slot not valid");

  a_grown_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (grown_r <= SLOTS_C) && (live_r <= grown_r))
    else $error("grown or live count out of range");

  a_take_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_EXEC))
    else $error("taken transaction not executed");

endmodule

// File: dv/slot_pool_allocator_with_aging_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_allocator_with_aging_checker
// Passive scoreboard for the slot pool allocator. It follows register writes
// and accepted request transactions and keeps its own copy of the slot table
// and counters. From these it works out the result of every request. It
// compares each accepted result, field by field, against the oldest predicted
// result and counts every difference.
// ----------------------------------------------------------------------------
module slot_pool_allocator_with_aging_checker
  import spa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  spa_req_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  spa_res_t             out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output int                   failures,
  output int                   pending
);

  localparam int NSLOT = SLOTS_DEFAULT;

  logic [CNT_W-1:0] limit_reg;
  logic             sweep_on;
  logic [VAL_W-1:0] idle_reg;

  logic [NSLOT-1:0] valid_map;
  logic [NSLOT-1:0] busy_map;
  logic [VAL_W-1:0] birth_tab [NSLOT];
  int unsigned      grown_n;
  int unsigned      live_n;
  logic [VAL_W-1:0] grant_cnt;
  logic [VAL_W-1:0] reuse_cnt;
  logic [VAL_W-1:0] fresh_cnt;
  logic [VAL_W-1:0] release_cnt;

  spa_res_t    result_q [$];
  int unsigned result_no;

  function automatic int unsigned pool_cap();
    if (limit_reg == 0 || limit_reg > NSLOT) begin
      return NSLOT;
    end
    return 32'(limit_reg);
  endfunction

  task automatic clear_counters();
    grant_cnt   = '0;
    reuse_cnt   = '0;
    fresh_cnt   = '0;
    release_cnt = '0;
  endtask

  task automatic serve_request(input spa_req_t rq, output spa_res_t rs);
    int unsigned      i;
    int unsigned      n;
    int unsigned      swept;
    logic [VAL_W-1:0] age;
    rs    = '0;
    swept = 0;
    case (rq.req_type)
      REQ_ALLOC: begin
        i = 0;
        while (i < grown_n && !(valid_map[i] && !busy_map[i])) begin
          i++;
        end
        if (i < grown_n) begin
          busy_map[i]     = 1'b1;
          rs.granted_slot = IDX_W'(i);
          rs.reused       = 1'b1;
          rs.ok           = 1'b1;
          live_n++;
          grant_cnt++;
          reuse_cnt++;
        end else if (grown_n < pool_cap()) begin
          i               = grown_n;
          valid_map[i]    = 1'b1;
          busy_map[i]     = 1'b1;
          birth_tab[i]    = rq.now_time;
          grown_n++;
          rs.granted_slot = IDX_W'(i);
          rs.ok           = 1'b1;
          live_n++;
          grant_cnt++;
          fresh_cnt++;
        end
      end
      REQ_FREE: begin
        if (rq.slot_index < grown_n && busy_map[rq.slot_index]) begin
          busy_map[rq.slot_index] = 1'b0;
          if (live_n > 0) begin
            live_n--;
          end
          release_cnt++;
          rs.ok = 1'b1;
        end
      end
      REQ_SWEEP: begin
        if (sweep_on) begin
          for (i = 0; i < grown_n; i++) begin
            age = rq.now_time - birth_tab[i];
            if (valid_map[i] && !busy_map[i] && age > idle_reg) begin
              valid_map[i] = 1'b0;
              swept++;
            end
          end
        end
        rs.swept_count = CNT_W'(swept);
        rs.ok          = (swept != 0);
      end
      REQ_CLEAR: begin
        clear_counters();
        rs.ok = 1'b1;
      end
      REQ_INIT: begin
        if (rq.prefill_count != 0) begin
          n = pool_cap();
          if (rq.prefill_count < n) begin
            n = 32'(rq.prefill_count);
          end
          valid_map = '0;
          busy_map  = '0;
          for (i = 0; i < n; i++) begin
            valid_map[i] = 1'b1;
            birth_tab[i] = rq.now_time;
          end
          grown_n = n;
          live_n  = 0;
          clear_counters();
          rs.ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    rs.live_count    = CNT_W'(live_n);
    rs.grown_count   = CNT_W'(grown_n);
    rs.grant_total   = grant_cnt;
    rs.reuse_total   = reuse_cnt;
    rs.fresh_total   = fresh_cnt;
    rs.release_total = release_cnt;
  endtask

  task automatic report_mismatch(input string line);
    $display("[%0t] %s", $time, line);
    failures++;
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] got,
                             input logic [VAL_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got 0x%0h, want 0x%0h",
                                result_no, name, got, want));
    end
  endtask

  always @(posedge clk) begin : track
    spa_res_t want;
    spa_res_t pred;
    int       k;
    if (!rst_n) begin
      limit_reg = SLOT_LIMIT_DEFAULT;
      sweep_on  = SWEEP_ENABLE_DEFAULT;
      idle_reg  = IDLE_LIMIT_DEFAULT;
      valid_map = '0;
      busy_map  = '0;
      for (k = 0; k < NSLOT; k++) begin
        birth_tab[k] = '0;
      end
      grown_n   = 0;
      live_n    = 0;
      clear_counters();
      result_q.delete();
      failures  = 0;
      result_no = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SLOT_LIMIT:   limit_reg = cfg_wdata[CNT_W-1:0];
          CFG_SWEEP_ENABLE: sweep_on  = cfg_wdata[0];
          CFG_IDLE_LIMIT:   idle_reg  = cfg_wdata;
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (result_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", result_no));
        end else begin
          want = result_q.pop_front();
          check_field("ok", VAL_W'(out_data.ok), VAL_W'(want.ok));
          check_field("granted_slot", VAL_W'(out_data.granted_slot),
                      VAL_W'(want.granted_slot));
          check_field("reused", VAL_W'(out_data.reused), VAL_W'(want.reused));
          check_field("swept_count", VAL_W'(out_data.swept_count),
                      VAL_W'(want.swept_count));
          check_field("live_count", VAL_W'(out_data.live_count),
                      VAL_W'(want.live_count));
          check_field("grown_count", VAL_W'(out_data.grown_count),
                      VAL_W'(want.grown_count));
          check_field("grant_total", out_data.grant_total, want.grant_total);
          check_field("reuse_total", out_data.reuse_total, want.reuse_total);
          check_field("fresh_total", out_data.fresh_total, want.fresh_total);
          check_field("release_total", out_data.release_total, want.release_total);
        end
        result_no++;
      end
      if (in_valid && in_ready) begin
        serve_request(in_data, pred);
        result_q.push_back(pred);
      end
    end
    pending = result_q.size();
  end

endmodule

// File: dv/slot_pool_allocator_with_aging_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slot_pool_allocator_with_aging_tb
// Top level bench for the slot pool allocator. A short directed run covers
// grow, reuse, failed allocate, ignored frees, wrapping ages, disabled sweep,
// init saturation and unknown requests. Six random phases then step through
// register settings and idling patterns, with a long result hold-off and a
// full drain pause. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
module slot_pool_allocator_with_aging_tb;
  import spa_pkg::*;

  localparam int               PHASE_ITEMS    = 275;
  localparam int               HOLD_CYCLES    = 300;
  localparam int               DRAIN_CYCLES   = 150;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_UNKNOWN_HI = 3'd7;
  localparam logic [VAL_W-1:0] TOP_VALUE      = '1;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_wdata;
  int                   failures;
  int                   pending;
  int                   src_idle_pct;
  int                   sink_idle_pct;
  int                   hold_asked;
  int                   hold_done;

  spa_stream_if #(.payload_t(spa_req_t)) in_ch ();
  spa_stream_if #(.payload_t(spa_res_t)) out_ch ();

  slot_pool_allocator_with_aging dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  slot_pool_allocator_with_aging_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("slot_pool_allocator_with_aging: mismatch");
    $finish;
  end

  initial begin
    out_ch.ready = 1'b0;
    hold_done    = 0;
    forever begin
      @(negedge clk);
      if (hold_done != hold_asked) begin
        hold_done = hold_asked;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  function automatic spa_req_t make_req(input logic [REQ_W-1:0] kind,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [VAL_W-1:0] fval,
                                        input logic [VAL_W-1:0] now,
                                        input logic [CNT_W-1:0] pre);
    spa_req_t rq;
    rq.req_type      = kind;
    rq.slot_index    = idx;
    rq.final_value   = fval;
    rq.now_time      = now;
    rq.prefill_count = pre;
    return rq;
  endfunction

  task automatic send_req(input spa_req_t rq);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= rq;
    do begin
      @(posedge clk);
    end while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    do begin
      @(negedge clk);
    end while (pending != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int               p;
    int               n;
    int               roll;
    int               lim_hint;
    int unsigned      step_max;
    logic [REQ_W-1:0] kind;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] pre;
    logic [CNT_W-1:0] lim_v;
    logic             en_v;
    logic [VAL_W-1:0] idle_v;
    logic [VAL_W-1:0] now_v;
    logic [VAL_W-1:0] clock_now;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.data    = '0;
    src_idle_pct  = 32;
    sink_idle_pct = 73;
    hold_asked    = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    send_req(make_req(REQ_ALLOC, 0, 0, 0, 0));
    send_req(make_req(REQ_FREE, 0, TOP_VALUE, 0, 0));
    send_req(make_req(REQ_FREE, 0, 0, 0, 0));
    send_req(make_req(REQ_FREE, 63, 0, 0, 0));
    send_req(make_req(REQ_ALLOC, 0, 0, 1, 0));
    send_req(make_req(REQ_SWEEP, 0, 0, TOP_VALUE, 0));
    send_req(make_req(REQ_FREE, 0, 0, 0, 0));
    send_req(make_req(REQ_SWEEP, 0, 0, 0, 0));
    send_req(make_req(REQ_SWEEP, 0, 0, TOP_VALUE, 0));
    send_req(make_req(REQ_ALLOC, 0, 0, 7, 0));
    send_req(make_req(REQ_CLEAR, 0, 0, 0, 0));
    send_req(make_req(REQ_UNKNOWN_LO, 63, TOP_VALUE, TOP_VALUE, 127));
    send_req(make_req(REQ_UNKNOWN_HI, 63, TOP_VALUE, TOP_VALUE, 127));
    send_req(make_req(REQ_INIT, 0, 0, 0, 0));
    send_req(make_req(REQ_INIT, 0, 0, TOP_VALUE, 127));
    send_req(make_req(REQ_ALLOC, 0, 0, 0, 0));
    send_req(make_req(REQ_SWEEP, 0, 0, 64'd5000000000, 0));
    send_req(make_req(REQ_ALLOC, 0, 0, 0, 0));
    send_req(make_req(REQ_FREE, 63, 0, 0, 0));
    send_req(make_req(REQ_FREE, 0, 0, 0, 0));
    wait_drain();
    write_reg(CFG_SLOT_LIMIT, 127);
    write_reg(CFG_SWEEP_ENABLE, 0);
    write_reg(CFG_IDLE_LIMIT, 0);
    send_req(make_req(REQ_INIT, 0, 0, 5, 1));
    send_req(make_req(REQ_SWEEP, 0, 0, 1000, 0));
    wait_drain();
    write_reg(CFG_SLOT_LIMIT, 2);
    write_reg(CFG_SWEEP_ENABLE, 1);
    send_req(make_req(REQ_INIT, 0, 0, 0, 64));
    send_req(make_req(REQ_ALLOC, 0, 0, 0, 0));
    send_req(make_req(REQ_ALLOC, 0, 0, 0, 0));
    send_req(make_req(REQ_ALLOC, 0, 0, 0, 0));
    send_req(make_req(REQ_FREE, 1, 0, 0, 0));
    send_req(make_req(REQ_SWEEP, 0, 0, 9, 0));

    for (p = 0; p < 6; p++) begin
      wait_drain();
      case (p)
        0: begin
          lim_v = 0;   en_v = 1'b1; idle_v = IDLE_LIMIT_DEFAULT;
          step_max = 1_000_000_000; lim_hint = 64;
        end
        1: begin
          lim_v = 1;   en_v = 1'b1; idle_v = 0;
          step_max = 3; lim_hint = 1;
        end
        2: begin
          lim_v = 64;  en_v = 1'b0; idle_v = TOP_VALUE;
          step_max = 32'hFFFF_FFFF; lim_hint = 64;
        end
        3: begin
          lim_v = CNT_W'($urandom_range(63, 2)); en_v = 1'b1;
          idle_v = 64'($urandom_range(2000, 50));
          step_max = 300; lim_hint = int'(lim_v);
        end
        4: begin
          lim_v = 127; en_v = 1'b1; idle_v = 1000;
          step_max = 200; lim_hint = 64;
        end
        default: begin
          lim_v = 8;   en_v = 1'b1; idle_v = 100;
          step_max = 40; lim_hint = 8;
        end
      endcase
      if (p < 2) begin
        src_idle_pct  = 32;
        sink_idle_pct = 73;
      end else if (p < 4) begin
        src_idle_pct  = 73;
        sink_idle_pct = 32;
      end else begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      write_reg(CFG_SLOT_LIMIT, CFG_DAT_W'(lim_v));
      write_reg(CFG_SWEEP_ENABLE, CFG_DAT_W'(en_v));
      write_reg(CFG_IDLE_LIMIT, idle_v);
      clock_now = TOP_VALUE - 64'(step_max) * 64'($urandom_range(50));

      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n == 100 && (p == 0 || p == 4)) begin
          hold_asked++;
        end
        if (n == 150 && p == 1) begin
          wait_drain();
        end
        roll = $urandom_range(99);
        if (roll < 40) begin
          kind = REQ_ALLOC;
        end else if (roll < 73) begin
          kind = REQ_FREE;
        end else if (roll < 85) begin
          kind = REQ_SWEEP;
        end else if (roll < 88) begin
          kind = REQ_CLEAR;
        end else if (roll < 95) begin
          kind = REQ_INIT;
        end else begin
          kind = REQ_W'($urandom_range(REQ_UNKNOWN_HI, REQ_UNKNOWN_LO));
        end
        clock_now = clock_now + 64'($urandom_range(step_max));
        now_v = ($urandom_range(99) < 8) ? {$urandom, $urandom} : clock_now;
        if (kind == REQ_FREE && $urandom_range(3) != 0) begin
          idx = IDX_W'($urandom_range(lim_hint - 1));
        end else begin
          idx = IDX_W'($urandom_range(63));
        end
        if (kind != REQ_INIT) begin
          pre = CNT_W'($urandom_range(127));
        end else begin
          roll = $urandom_range(9);
          if (roll == 0) begin
            pre = 0;
          end else if (roll < 3) begin
            pre = CNT_W'($urandom_range(127, 64));
          end else begin
            pre = CNT_W'($urandom_range(lim_hint, 1));
          end
        end
        send_req(make_req(kind, idx, {$urandom, $urandom}, now_v, pre));
      end
    end

    wait_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (failures == 0 && pending == 0) begin
      $display("slot_pool_allocator_with_aging: match");
    end else begin
      $display("slot_pool_allocator_with_aging: mismatch");
    end
    $finish;
  end

endmodule
